[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define BCER_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, during reset as well.
`define BCER_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define BCER_ASSERT(name, prop, msg)
`define BCER_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

[rtl/bcer_pkg.sv]
package bcer_pkg;

  localparam int CNT_W = 16;
  localparam int CMP_W = CNT_W + 18;
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << CNT_W) - 64'd1);

  localparam int MAX_RES = 4;
  localparam int RES_W = $clog2(MAX_RES + 1);
  localparam int IDX_W = $clog2(MAX_RES);
  localparam int NUM_EV = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END = 1'b1;

  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] COMMA = 8'h2C;
  localparam logic [7:0] ESC0 = 8'hE2;
  localparam logic [7:0] ESC1 = 8'h80;
  localparam logic [7:0] ESC2 = 8'h9A;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SINGLE,
    EV_ESCAPE
  } bcer_ev_e;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data_bytes;
    logic [RES_W-1:0]        nres;
    logic                    is_end;
    logic [15:0]             line_length;
  } bcer_entry_t;

endpackage

[rtl/bcer_if.sv]
interface bcer_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_in;

  modport source(output valid, action, byte_in, input ready);
  modport sink(input valid, action, byte_in, output ready);
endinterface

interface bcer_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        is_end_record;
  logic [15:0] line_length;
  logic        last;

  modport source(output valid, byte_out, is_end_record, line_length, last, input ready);
  modport sink(input valid, byte_out, is_end_record, line_length, last, output ready);
endinterface

interface bcer_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[rtl/bcer_front.sv]
`include "assert_macros.svh"

module bcer_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bcer_cfg_if.sink             cfg_i,
  bcer_in_if.sink              in_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output bcer_pkg::bcer_entry_t push_entry_o
);
  import bcer_pkg::*;

  logic [15:0]            cap_q;
  logic                   h1_q, h1_d;
  logic                   h2_q, h2_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   in_fire;
  logic                   end_rec;
  bcer_ev_e               ev_kind [NUM_EV];
  logic [NUM_EV-1:0][7:0] ev_byte;
  logic [CMP_W-1:0]       cap_x;
  logic [CMP_W-1:0]       cap_eff;
  logic [CMP_W-1:0]       cnt;
  logic [RES_W-1:0]       n;
  logic [MAX_RES-1:0][7:0] slots;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = push_ready_i;
  assign in_fire     = in_i.valid && push_ready_i;

  assign cap_x   = CMP_W'(cap_q);
  assign cap_eff = (cap_x < CNT_MAX) ? cap_x : CNT_MAX;

  always_comb begin
    h1_d    = h1_q;
    h2_d    = h2_q;
    end_rec = 1'b0;
    ev_byte = '0;
    for (int i = 0; i < NUM_EV; i++) begin
      ev_kind[i] = EV_NONE;
    end
    if (in_i.action == ACT_END) begin
      h1_d    = 1'b0;
      h2_d    = 1'b0;
      end_rec = 1'b1;
      if (h1_q) begin
        if (h2_q) begin
          ev_kind[0] = EV_SINGLE;
          ev_byte[0] = BSLASH;
        end
        ev_kind[1] = EV_SINGLE;
        ev_byte[1] = BSLASH;
      end else if (h2_q) begin
        ev_kind[1] = EV_SINGLE;
        ev_byte[1] = BSLASH;
      end
    end else if (h1_q) begin
      h1_d = 1'b0;
      if (h2_q) begin
        ev_kind[0] = EV_SINGLE;
        ev_byte[0] = BSLASH;
      end
      if (in_i.byte_in == BSLASH) begin
        h2_d = 1'b1;
      end else if (in_i.byte_in == COMMA) begin
        h2_d       = 1'b0;
        ev_kind[1] = EV_ESCAPE;
      end else begin
        h2_d       = 1'b0;
        ev_kind[1] = EV_SINGLE;
        ev_byte[1] = BSLASH;
        ev_kind[2] = EV_SINGLE;
        ev_byte[2] = in_i.byte_in;
      end
    end else if (in_i.byte_in == BSLASH) begin
      h1_d = 1'b1;
    end else if (h2_q) begin
      h2_d = 1'b0;
      if (in_i.byte_in == COMMA) begin
        ev_kind[1] = EV_ESCAPE;
      end else begin
        ev_kind[1] = EV_SINGLE;
        ev_byte[1] = BSLASH;
        ev_kind[2] = EV_SINGLE;
        ev_byte[2] = in_i.byte_in;
      end
    end else begin
      ev_kind[2] = EV_SINGLE;
      ev_byte[2] = in_i.byte_in;
    end
  end

  // Apply the capacity limit to the events in order and pack the bytes.
  always_comb begin
    cnt   = CMP_W'(cnt_q);
    n     = '0;
    slots = '0;
    for (int i = 0; i < NUM_EV; i++) begin
      case (ev_kind[i])
        EV_SINGLE: begin
          if (cnt < cap_eff) begin
            slots[n[IDX_W-1:0]] = ev_byte[i];
            n   = n + RES_W'(1);
            cnt = cnt + CMP_W'(1);
          end
        end
        EV_ESCAPE: begin
          if (cnt + CMP_W'(3) <= cap_eff) begin
            slots[n[IDX_W-1:0]]                = ESC0;
            slots[n[IDX_W-1:0] + IDX_W'(1)]    = ESC1;
            slots[n[IDX_W-1:0] + IDX_W'(2)]    = ESC2;
            n   = n + RES_W'(3);
            cnt = cnt + CMP_W'(3);
          end
        end
        default: begin
        end
      endcase
    end
    if (end_rec) begin
      slots[n[IDX_W-1:0]] = 8'h00;
      n     = n + RES_W'(1);
      cnt_d = '0;
    end else begin
      cnt_d = cnt[CNT_W-1:0];
    end
  end

  assign push_valid_o             = in_fire && (n != '0);
  assign push_entry_o.data_bytes  = slots;
  assign push_entry_o.nres        = n;
  assign push_entry_o.is_end      = end_rec;
  assign push_entry_o.line_length = cnt[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      h1_q  <= 1'b0;
      h2_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
      if (in_fire) begin
        h1_q  <= h1_d;
        h2_q  <= h2_d;
        cnt_q <= cnt_d;
      end
    end
  end

  `BCER_ASSERT(a_end_clears_line, in_fire && in_i.action == ACT_END |=> !h1_q && !h2_q && cnt_q == '0, "line state not cleared after end of line")
  `BCER_ASSERT(a_end_pushes, in_fire && in_i.action == ACT_END |-> push_valid_o && push_entry_o.is_end, "end of line produced no record")

endmodule

[rtl/bcer_fifo.sv]
`include "assert_macros.svh"

module bcer_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  bcer_pkg::bcer_entry_t push_entry_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output bcer_pkg::bcer_entry_t pop_entry_o
);
  import bcer_pkg::*;

  bcer_entry_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `BCER_ASSERT(a_count_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

[rtl/bcer_back.sv]
`include "assert_macros.svh"

module bcer_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  bcer_pkg::bcer_entry_t pop_entry_i,
  bcer_out_if.source            out_o
);
  import bcer_pkg::*;

  logic             out_valid_q;
  logic [IDX_W-1:0] idx_q;
  logic             load;
  logic             is_last;
  logic [7:0]       byte_q;
  logic             end_q;
  logic [15:0]      len_q;
  logic             last_q;

  assign load        = pop_valid_i && (!out_valid_q || out_o.ready);
  assign is_last     = (RES_W'(idx_q) + RES_W'(1)) == pop_entry_i.nres;
  assign pop_ready_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + IDX_W'(1);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      end_q  <= is_last && pop_entry_i.is_end;
      last_q <= is_last;
      if (is_last && pop_entry_i.is_end) begin
        byte_q <= 8'h00;
        len_q  <= pop_entry_i.line_length;
      end else begin
        byte_q <= pop_entry_i.data_bytes[idx_q];
        len_q  <= 16'h0000;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.byte_out      = byte_q;
  assign out_o.is_end_record = end_q;
  assign out_o.line_length   = len_q;
  assign out_o.last          = last_q;

  `BCER_ASSERT(a_idx_in_range, pop_valid_i |-> RES_W'(idx_q) < pop_entry_i.nres && pop_entry_i.nres != '0, "slot index beyond entry")
  `BCER_ASSERT(a_end_record_last, out_valid_q && end_q |-> last_q && byte_q == 8'h00, "end record is not the last transfer")

endmodule

[rtl/backslash_comma_escape_rewriter.sv]
// Backslash and comma escape rewriter.
//
// Channels: in_i carries one line byte (action 0) or an end of line (action 1).
// out_o carries rewritten bytes and, per line, one end record with the length.
// cfg_i writes the output capacity; write it only while the block is idle.
// A transfer happens on a rising edge with valid and ready both high.
//
// An input byte is classified and limited against the capacity in the cycle
// it is taken, and its zero to four results go into a four-entry queue. The
// back end sends one result per cycle while the receiver is ready, from the
// queue head through an output register. Input accepts one item per cycle
// while the queue has room; the sustained rate is one output transfer per
// cycle while the receiver is ready, and an item that expands to several
// bytes leaves the queue once its last result is loaded for output.
//
// Reset clears the held backslashes, the line byte count and the queue, and
// sets the capacity to 65535. When the receiver stalls, the output holds and
// the queue fills, after which in_i.ready drops until space frees up.
module backslash_comma_escape_rewriter (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcer_cfg_if.sink   cfg_i,
  bcer_in_if.sink    in_i,
  bcer_out_if.source out_o
);
  import bcer_pkg::*;

  logic        push_valid, push_ready;
  bcer_entry_t push_entry;
  logic        pop_valid, pop_ready;
  bcer_entry_t pop_entry;

  bcer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_entry_o(push_entry)
  );

  bcer_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_entry_o (pop_entry)
  );

  bcer_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_entry_i(pop_entry),
    .out_o      (out_o)
  );

endmodule
